>>> src/ccrc_pkg.sv
// ----------------------------------------------------------------------------
// ccrc_pkg
// Shared types and constants for the coin classifier and roll counter.
// ----------------------------------------------------------------------------
package ccrc_pkg;

    localparam int NUM_KINDS = 5;

    typedef enum logic [2:0] {
        DEST_NICKEL  = 3'd0,
        DEST_DIME    = 3'd1,
        DEST_QUARTER = 3'd2,
        DEST_LOONIE  = 3'd3,
        DEST_TOONIE  = 3'd4,
        DEST_OTHER   = 3'd5,
        DEST_BENT    = 3'd6,
        DEST_REJECT  = 3'd7
    } dest_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_NICKEL_ROLL  = 3'd0,
        REG_DIME_ROLL    = 3'd1,
        REG_QUARTER_ROLL = 3'd2,
        REG_LOONIE_ROLL  = 3'd3,
        REG_TOONIE_ROLL  = 3'd4,
        REG_BENT_LIMIT   = 3'd5,
        REG_OTHER_LIMIT  = 3'd6,
        REG_UNUSED       = 3'd7
    } reg_index_t;

    localparam int WEIGHT_W   = 10;
    localparam int DIAM_W     = 10;
    localparam int ROLL_W     = 6;
    localparam int LIMIT_W    = 13;
    localparam int HOLD_W     = 14;
    localparam int COUNT_W    = 13;
    localparam int TOTAL16_W  = 16;
    localparam int TOTAL24_W  = 24;
    localparam int SCALED_W_W = 18;
    localparam int SCALED_D_W = 16;

    localparam logic [SCALED_W_W-1:0] WEIGHT_SCALE = 18'd1000;
    localparam logic [SCALED_D_W-1:0] DIAM_SCALE   = 16'd200;

    // window bounds: grams*100*255 and (mm*100 - 1000)*17
    localparam logic [SCALED_W_W-1:0] WT_LO [NUM_KINDS] = '{
        18'(255*360), 18'(255*130), 18'(255*400), 18'(255*650), 18'(255*675)};
    localparam logic [SCALED_W_W-1:0] WT_HI [NUM_KINDS] = '{
        18'(255*430), 18'(255*220), 18'(255*480), 18'(255*750), 18'(255*785)};
    localparam logic [SCALED_D_W-1:0] DM_LO [NUM_KINDS] = '{
        16'(17*1020), 16'(17*730), 16'(17*1280), 16'(17*1500), 16'(17*1690)};
    localparam logic [SCALED_D_W-1:0] DM_HI [NUM_KINDS] = '{
        16'(17*1180), 16'(17*870), 16'(17*1460), 16'(17*1700), 16'(17*1910)};

    localparam logic [ROLL_W-1:0] ROLL_SIZE_RESET [NUM_KINDS] = '{
        6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
    localparam logic [LIMIT_W-1:0] BENT_LIMIT_RESET  = 13'd2550;
    localparam logic [LIMIT_W-1:0] OTHER_LIMIT_RESET = 13'd5100;

    // one classified coin on its way to the tally stage
    typedef struct packed {
        dest_t               dest;
        logic [WEIGHT_W-1:0] weight;
    } coin_item_t;

endpackage

>>> src/ccrc_classify.sv
// ----------------------------------------------------------------------------
// ccrc_classify
// Sorts one reading into bent, rejected, a coin kind or the other container.
// ----------------------------------------------------------------------------
module ccrc_classify
    import ccrc_pkg::*;
(
    input  logic [WEIGHT_W-1:0] weight_code,
    input  logic [DIAM_W-1:0]   diameter_code,
    input  logic                is_bent,
    input  logic [1:0]          face_match,
    output coin_item_t          item
);

    logic                  weight_ok;
    logic                  diam_ok;
    logic [SCALED_W_W-1:0] wt_scaled;
    logic [SCALED_D_W-1:0] dm_scaled;
    logic [NUM_KINDS-1:0]  hit;
    dest_t                 kind_dest;

    assign weight_ok = (weight_code != '0) && (weight_code[WEIGHT_W-1:8] == '0);
    assign diam_ok   = (diameter_code != '0) && (diameter_code[DIAM_W-1:8] == '0);

    assign wt_scaled = SCALED_W_W'(weight_code[7:0]) * WEIGHT_SCALE;
    assign dm_scaled = SCALED_D_W'(diameter_code[7:0]) * DIAM_SCALE;

    always_comb
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            hit[k] = (wt_scaled >= WT_LO[k]) && (wt_scaled <= WT_HI[k]) &&
                     (dm_scaled >= DM_LO[k]) && (dm_scaled <= DM_HI[k]);
        end
    end

    // lowest kind wins
    always_comb
    begin
        kind_dest = DEST_OTHER;
        for (int k = NUM_KINDS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                kind_dest = dest_t'(3'(k));
            end
        end
    end

    always_comb
    begin
        item.weight = weight_code;
        if (is_bent)
        begin
            item.dest = DEST_BENT;
        end
        else if (!weight_ok || !diam_ok)
        begin
            item.dest = DEST_REJECT;
        end
        else if (face_match != 2'd0)
        begin
            item.dest = DEST_OTHER;
        end
        else
        begin
            item.dest = kind_dest;
        end
    end

endmodule

>>> src/ccrc_queue.sv
// ----------------------------------------------------------------------------
// ccrc_queue
// Two-entry queue between the classifier and the tally stage.
// ----------------------------------------------------------------------------
module ccrc_queue
    import ccrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  coin_item_t push_item,
    output logic       full,
    input  logic       pop,
    output coin_item_t pop_item,
    output logic       not_empty
);

    coin_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/ccrc_tally.sv
// ----------------------------------------------------------------------------
// ccrc_tally
// Roll and container counters, configuration registers and result register.
// ----------------------------------------------------------------------------
module ccrc_tally
    import ccrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               item_valid,
    input  coin_item_t         item,
    output logic               item_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [111:0]       m_tdata,
    output logic [2:0]         m_tuser
);

    // configuration
    logic [ROLL_W-1:0]    roll_size_reg [NUM_KINDS];
    logic [LIMIT_W-1:0]   bent_limit_reg;
    logic [LIMIT_W-1:0]   other_limit_reg;

    // counters
    logic [ROLL_W-1:0]    roll_count_reg  [NUM_KINDS];
    logic [ROLL_W-1:0]    roll_count_next [NUM_KINDS];
    logic [TOTAL16_W-1:0] rolls_made_reg  [NUM_KINDS];
    logic [TOTAL16_W-1:0] rolls_made_next [NUM_KINDS];
    logic [HOLD_W-1:0]    bent_hold_reg;
    logic [HOLD_W-1:0]    bent_hold_next;
    logic [HOLD_W-1:0]    other_hold_reg;
    logic [HOLD_W-1:0]    other_hold_next;
    logic [COUNT_W-1:0]   other_count_reg;
    logic [COUNT_W-1:0]   other_count_next;
    logic [TOTAL16_W-1:0] other_filled_reg;
    logic [TOTAL16_W-1:0] other_filled_next;
    logic [TOTAL16_W-1:0] other_total_reg;
    logic [TOTAL16_W-1:0] other_total_next;
    logic [TOTAL24_W-1:0] other_wt_total_reg;
    logic [TOTAL24_W-1:0] other_wt_total_next;
    logic [TOTAL24_W-1:0] bent_wt_total_reg;
    logic [TOTAL24_W-1:0] bent_wt_total_next;

    // result register
    logic                 out_valid_reg;
    logic [2:0]           out_dest_reg;
    logic [COUNT_W-1:0]   out_coins_reg;
    logic [COUNT_W-1:0]   out_coins_next;
    logic                 out_repl_reg;
    logic                 out_repl_next;
    logic [TOTAL16_W-1:0] out_filled_reg;
    logic [TOTAL16_W-1:0] out_filled_next;
    logic [HOLD_W-1:0]    out_hold_reg;
    logic [HOLD_W-1:0]    out_hold_next;

    logic [2:0]           kind_idx;
    logic                 is_roll;
    logic [ROLL_W-1:0]    cnt_inc;
    logic [HOLD_W-1:0]    bent_sum;
    logic [HOLD_W-1:0]    other_sum;

    function automatic logic [TOTAL16_W-1:0] sat_inc16(input logic [TOTAL16_W-1:0] a);
        return (a == '1) ? a : a + 16'd1;
    endfunction

    function automatic logic [TOTAL24_W-1:0] sat_add24(input logic [TOTAL24_W-1:0] a,
                                                        input logic [WEIGHT_W-1:0]  b);
        logic [TOTAL24_W:0] s;
        s = {1'b0, a} + (TOTAL24_W + 1)'(b);
        return s[TOTAL24_W] ? '1 : s[TOTAL24_W-1:0];
    endfunction

    assign item_pop = item_valid && (!out_valid_reg || m_tready);

    assign is_roll  = (item.dest <= DEST_TOONIE);
    assign kind_idx = is_roll ? item.dest : 3'd0;
    assign cnt_inc  = roll_count_reg[kind_idx] + 6'd1;
    assign bent_sum = bent_hold_reg + HOLD_W'(item.weight);
    assign other_sum = other_hold_reg + HOLD_W'(item.weight);

    always_comb
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            roll_count_next[k] = roll_count_reg[k];
            rolls_made_next[k] = rolls_made_reg[k];
        end
        bent_hold_next      = bent_hold_reg;
        other_hold_next     = other_hold_reg;
        other_count_next    = other_count_reg;
        other_filled_next   = other_filled_reg;
        other_total_next    = other_total_reg;
        other_wt_total_next = other_wt_total_reg;
        bent_wt_total_next  = bent_wt_total_reg;
        out_coins_next      = '0;
        out_repl_next       = 1'b0;
        out_filled_next     = '0;
        out_hold_next       = '0;

        case (item.dest)
            DEST_NICKEL, DEST_DIME, DEST_QUARTER, DEST_LOONIE, DEST_TOONIE:
            begin
                // count wraps in six bits; a size below the count fills at once
                if (cnt_inc >= roll_size_reg[kind_idx])
                begin
                    roll_count_next[kind_idx] = '0;
                    rolls_made_next[kind_idx] = sat_inc16(rolls_made_reg[kind_idx]);
                    out_repl_next             = 1'b1;
                end
                else
                begin
                    roll_count_next[kind_idx] = cnt_inc;
                end
                out_coins_next  = COUNT_W'(roll_count_next[kind_idx]);
                out_filled_next = rolls_made_next[kind_idx];
            end
            DEST_OTHER:
            begin
                other_total_next    = sat_inc16(other_total_reg);
                other_wt_total_next = sat_add24(other_wt_total_reg, item.weight);
                if (other_sum > HOLD_W'(other_limit_reg))
                begin
                    other_filled_next = sat_inc16(other_filled_reg);
                    other_count_next  = COUNT_W'(1);
                    other_hold_next   = HOLD_W'(item.weight);
                    out_repl_next     = 1'b1;
                end
                else
                begin
                    other_count_next = (other_count_reg == '1) ? other_count_reg
                                                               : other_count_reg + 13'd1;
                    other_hold_next  = other_sum;
                end
                out_coins_next  = other_count_next;
                out_filled_next = other_filled_next;
                out_hold_next   = other_hold_next;
            end
            DEST_BENT:
            begin
                bent_wt_total_next = sat_add24(bent_wt_total_reg, item.weight);
                if (bent_sum > HOLD_W'(bent_limit_reg))
                begin
                    bent_hold_next = HOLD_W'(item.weight);
                    out_repl_next  = 1'b1;
                end
                else
                begin
                    bent_hold_next = bent_sum;
                end
                out_hold_next = bent_hold_next;
            end
            default:
            begin
                out_coins_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                roll_size_reg[k]  <= ROLL_SIZE_RESET[k];
                roll_count_reg[k] <= '0;
                rolls_made_reg[k] <= '0;
            end
            bent_limit_reg     <= BENT_LIMIT_RESET;
            other_limit_reg    <= OTHER_LIMIT_RESET;
            bent_hold_reg      <= '0;
            other_hold_reg     <= '0;
            other_count_reg    <= '0;
            other_filled_reg   <= '0;
            other_total_reg    <= '0;
            other_wt_total_reg <= '0;
            bent_wt_total_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_NICKEL_ROLL, REG_DIME_ROLL, REG_QUARTER_ROLL,
                    REG_LOONIE_ROLL, REG_TOONIE_ROLL:
                        roll_size_reg[cfg_index] <= cfg_data[ROLL_W-1:0];
                    REG_BENT_LIMIT:  bent_limit_reg  <= cfg_data;
                    REG_OTHER_LIMIT: other_limit_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (item_pop)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    roll_count_reg[k] <= roll_count_next[k];
                    rolls_made_reg[k] <= rolls_made_next[k];
                end
                bent_hold_reg      <= bent_hold_next;
                other_hold_reg     <= other_hold_next;
                other_count_reg    <= other_count_next;
                other_filled_reg   <= other_filled_next;
                other_total_reg    <= other_total_next;
                other_wt_total_reg <= other_wt_total_next;
                bent_wt_total_reg  <= bent_wt_total_next;
                out_valid_reg      <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            out_dest_reg   <= item.dest;
            out_coins_reg  <= out_coins_next;
            out_repl_reg   <= out_repl_next;
            out_filled_reg <= out_filled_next;
            out_hold_reg   <= out_hold_next;
        end
    end

    // totals are read from the counter registers, which only move on a pop
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dest_reg;
    assign m_tdata  = {4'd0,
                       bent_wt_total_reg, other_wt_total_reg, other_total_reg,
                       out_hold_reg, out_filled_reg, out_repl_reg, out_coins_reg};

endmodule

>>> src/coin_classifier_roll_counter.sv
// ----------------------------------------------------------------------------
// coin_classifier_roll_counter
// Coin sorter: classifies each reading and keeps roll and container counts.
// ----------------------------------------------------------------------------
// One coin reading per word in, one result word out, in order. Sustained rate
// is one reading per clock while the master side accepts. The classifier
// (window compares, priority pick) feeds a two-entry queue; the tally stage
// pops one entry per cycle, unless the master side stalls, into a single
// result register, so up to three readings are absorbed while the master side
// stalls. Configuration is always ready; write it only while the block is
// idle. Bad register indexes are ignored.
module coin_classifier_roll_counter
    import ccrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // weight_code[9:0], diameter_code[19:10],
                                        // face_match[21:20], zero pad
    input  logic         s_axis_tuser,  // is_bent
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // coins_in_holder[12:0], holder_replaced[13],
                                        // holders_filled[29:14], holder_weight[43:30],
                                        // other_coin_total[59:44],
                                        // other_weight_total[83:60],
                                        // bent_weight_total[107:84], zero pad
    output logic [2:0]   m_axis_tuser,  // destination
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    coin_item_t class_item;
    coin_item_t head_item;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign cfg_ready     = 1'b1;

    ccrc_classify u_classify (
        .weight_code   (s_axis_tdata[9:0]),
        .diameter_code (s_axis_tdata[19:10]),
        .is_bent       (s_axis_tuser),
        .face_match    (s_axis_tdata[21:20]),
        .item          (class_item)
    );

    ccrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (class_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (head_item),
        .not_empty (q_not_empty)
    );

    ccrc_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_pop   (q_pop),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser)
    );

endmodule

>>> src/ccrc_checker.sv
// ----------------------------------------------------------------------------
// ccrc_checker
// Port-level checks on the result stream of the coin sorter.
// ----------------------------------------------------------------------------
module ccrc_checker
    import ccrc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // rejected coins touch no holder
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == DEST_REJECT) |-> (m_axis_tdata[43:0] == '0))
        else $error("rejected coin reported holder data");

    // rolls carry no weight and a count that fits six bits
    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser <= DEST_TOONIE) |->
            (m_axis_tdata[43:30] == '0) && (m_axis_tdata[12:6] == '0))
        else $error("roll result out of range");

    // bent coins have no count
    a_bent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == DEST_BENT) |->
            (m_axis_tdata[12:0] == '0) && (m_axis_tdata[29:14] == '0))
        else $error("bent coin reported a count");

endmodule

bind coin_classifier_roll_counter ccrc_checker u_ccrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for coin_classifier_roll_counter. Coin readings go in
// on the slave stream and result words come back on the master stream. Every
// accepted reading runs through a local model of the sorter: window
// classification, roll counters, bent and other containers, and saturating
// totals. Each result word is compared field by field against the oldest
// prediction. Directed edge cases come first, then register extremes, then a
// roll-size shrink. Random mixes, most with source and sink stalls, finish the run.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccrc_pkg::*;

    localparam logic [1:0] FACE_BOTH = 2'd0;
    localparam logic [1:0] FACE_ONE  = 2'd1;
    localparam logic [1:0] FACE_NONE = 2'd2;
    localparam logic [1:0] FACE_BAD  = 2'd3;

    localparam int STALL_LIMIT = 2000;

    // coin windows in hundredths of a gram and of a millimetre
    localparam int GRAM_LO [NUM_KINDS] = '{360, 130, 400, 650, 675};
    localparam int GRAM_HI [NUM_KINDS] = '{430, 220, 480, 750, 785};
    localparam int MM_LO   [NUM_KINDS] = '{2020, 1730, 2280, 2500, 2690};
    localparam int MM_HI   [NUM_KINDS] = '{2180, 1870, 2460, 2700, 2910};

    // raw code ranges that land inside each window, used only to aim stimulus
    localparam int AIM_W_LO [NUM_KINDS] = '{92, 34, 102, 166, 173};
    localparam int AIM_W_HI [NUM_KINDS] = '{109, 56, 122, 191, 200};
    localparam int AIM_D_LO [NUM_KINDS] = '{87, 63, 109, 128, 144};
    localparam int AIM_D_HI [NUM_KINDS] = '{100, 73, 124, 144, 162};

    typedef struct {
        logic [9:0] weight;
        logic [9:0] diam;
        logic       bent;
        logic [1:0] face;
    } coin_t;

    typedef struct {
        dest_t       dest;
        logic [12:0] coins;
        logic        repl;
        logic [15:0] filled;
        logic [13:0] load;
        logic [15:0] other_n;
        logic [23:0] other_wsum;
        logic [23:0] bent_wsum;
    } tally_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [12:0]  cfg_data = '0;

    // sorter model state and settings
    logic [5:0]  roll_len [NUM_KINDS] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
    logic [12:0] bent_cap = 13'd2550;
    logic [12:0] other_cap = 13'd5100;
    logic [5:0]  roll_fill [NUM_KINDS] = '{default: '0};
    logic [15:0] rolls_done [NUM_KINDS] = '{default: '0};
    logic [13:0] bent_load = '0;
    logic [13:0] other_load = '0;
    logic [12:0] other_count = '0;
    logic [15:0] other_full = '0;
    logic [15:0] other_n = '0;
    logic [23:0] other_wsum = '0;
    logic [23:0] bent_wsum = '0;

    tally_t tally_due [$];
    int     err_cnt = 0;
    int     src_idle_pct = 0;
    int     sink_idle_pct = 0;
    int     quiet_cycles = 0;

    coin_classifier_roll_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clip_add(int a, int b, int top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic bit coin_fits(int k, int w, int d);
        int wt = 1000 * w;
        int dm = 200 * d;
        return wt >= 255 * GRAM_LO[k] && wt <= 255 * GRAM_HI[k] &&
               dm >= 17 * (MM_LO[k] - 1000) && dm <= 17 * (MM_HI[k] - 1000);
    endfunction

    // classify one coin and update holders; returns the result word it causes
    function automatic tally_t sort_coin(coin_t c);
        tally_t r;
        int     w = c.weight;
        int     d = c.diam;
        int     kind = -1;
        r = '{dest: DEST_REJECT, default: '0};
        if (c.bent)
        begin
            r.dest = DEST_BENT;
            bent_wsum = clip_add(bent_wsum, w, 24'hFFFFFF);
            bent_load = bent_load + w;
            if (bent_load > bent_cap)
            begin
                bent_load = w;
                r.repl = 1'b1;
            end
            r.load = bent_load;
        end
        else if (w >= 1 && w <= 255 && d >= 1 && d <= 255)
        begin
            if (c.face == FACE_BOTH)
            begin
                for (int k = NUM_KINDS - 1; k >= 0; k--)
                begin
                    if (coin_fits(k, w, d))
                        kind = k;
                end
            end
            if (kind >= 0)
            begin
                r.dest = dest_t'(kind);
                roll_fill[kind] = roll_fill[kind] + 6'd1;
                if (roll_fill[kind] >= roll_len[kind])
                begin
                    rolls_done[kind] = clip_add(rolls_done[kind], 1, 16'hFFFF);
                    roll_fill[kind] = '0;
                    r.repl = 1'b1;
                end
                r.coins = roll_fill[kind];
                r.filled = rolls_done[kind];
            end
            else
            begin
                r.dest = DEST_OTHER;
                other_n = clip_add(other_n, 1, 16'hFFFF);
                other_wsum = clip_add(other_wsum, w, 24'hFFFFFF);
                other_count = clip_add(other_count, 1, 13'h1FFF);
                other_load = other_load + w;
                if (other_load > other_cap)
                begin
                    other_full = clip_add(other_full, 1, 16'hFFFF);
                    other_count = 13'd1;
                    other_load = w;
                    r.repl = 1'b1;
                end
                r.coins = other_count;
                r.filled = other_full;
                r.load = other_load;
            end
        end
        r.other_n = other_n;
        r.other_wsum = other_wsum;
        r.bent_wsum = bent_wsum;
        return r;
    endfunction

    function automatic coin_t mk_coin(int w, int d, bit bent, logic [1:0] face);
        coin_t c;
        c.weight = 10'(w);
        c.diam = 10'(d);
        c.bent = bent;
        c.face = face;
        return c;
    endfunction

    // mostly coins aimed at a window (edges included), plus bent coins,
    // in-range strays and full-range noise
    function automatic coin_t random_coin();
        coin_t c;
        int    pick = $urandom_range(99);
        int    k = $urandom_range(NUM_KINDS - 1);
        c = mk_coin(0, 0, 1'b0, FACE_BOTH);
        if (pick < 70)
        begin
            c.weight = 10'($urandom_range(AIM_W_HI[k] + 3, AIM_W_LO[k] - 3));
            c.diam = 10'($urandom_range(AIM_D_HI[k] + 3, AIM_D_LO[k] - 3));
            if ($urandom_range(99) < 15)
                c.face = 2'($urandom_range(3, 1));
        end
        else if (pick < 80)
        begin
            c.bent = 1'b1;
            c.weight = 10'($urandom);
            c.diam = 10'($urandom);
            c.face = 2'($urandom);
        end
        else if (pick < 90)
        begin
            c.weight = 10'($urandom_range(255, 1));
            c.diam = 10'($urandom_range(255, 1));
            c.face = 2'($urandom);
        end
        else
        begin
            c.weight = 10'($urandom);
            c.diam = 10'($urandom);
            c.face = 2'($urandom);
        end
        return c;
    endfunction

    // leaves tvalid high on return so back-to-back words need no bubble
    task automatic send_coin(input coin_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, c.face, c.diam, c.weight};
        s_axis_tuser <= c.bent;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tally_due.push_back(sort_coin(c));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tally_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [12:0] val, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_NICKEL_ROLL, REG_DIME_ROLL, REG_QUARTER_ROLL,
            REG_LOONIE_ROLL, REG_TOONIE_ROLL: roll_len[int'(idx)] = val[5:0];
            REG_BENT_LIMIT:  bent_cap = val;
            REG_OTHER_LIMIT: other_cap = val;
            default: ;
        endcase
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    function automatic void cmp_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic check_tally();
        tally_t want;
        if (tally_due.size() == 0)
        begin
            $error("result word with no coin pending");
            err_cnt++;
        end
        else
        begin
            want = tally_due.pop_front();
            cmp_field("destination", want.dest, m_axis_tuser);
            cmp_field("coins_in_holder", want.coins, m_axis_tdata[12:0]);
            cmp_field("holder_replaced", want.repl, m_axis_tdata[13]);
            cmp_field("holders_filled", want.filled, m_axis_tdata[29:14]);
            cmp_field("holder_weight", want.load, m_axis_tdata[43:30]);
            cmp_field("other_coin_total", want.other_n, m_axis_tdata[59:44]);
            cmp_field("other_weight_total", want.other_wsum, m_axis_tdata[83:60]);
            cmp_field("bent_weight_total", want.bent_wsum, m_axis_tdata[107:84]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_tally();
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // reset register values, no stalls
    task automatic test_directed_edges();
        // out-of-range readings
        send_coin(mk_coin(0, 0, 1'b0, FACE_BOTH));
        send_coin(mk_coin(1023, 1023, 1'b0, FACE_BOTH));
        send_coin(mk_coin(256, 100, 1'b0, FACE_BOTH));
        send_coin(mk_coin(100, 256, 1'b0, FACE_BOTH));
        send_coin(mk_coin(0, 100, 1'b0, FACE_BOTH));
        send_coin(mk_coin(100, 0, 1'b0, FACE_BOTH));
        // in range, outside every window
        send_coin(mk_coin(255, 255, 1'b0, FACE_BOTH));
        send_coin(mk_coin(1, 1, 1'b0, FACE_BOTH));
        // bent wins even with bad codes
        send_coin(mk_coin(1023, 0, 1'b1, FACE_BAD));
        send_coin(mk_coin(0, 1023, 1'b1, FACE_BOTH));
        send_coin(mk_coin(700, 500, 1'b1, FACE_NONE));
        send_coin(mk_coin(900, 20, 1'b1, FACE_ONE));
        // nickel with each face code; only both-match lands in the roll
        send_coin(mk_coin(100, 93, 1'b0, FACE_BOTH));
        send_coin(mk_coin(100, 93, 1'b0, FACE_ONE));
        send_coin(mk_coin(100, 93, 1'b0, FACE_NONE));
        send_coin(mk_coin(100, 93, 1'b0, FACE_BAD));
        send_coin(mk_coin(45, 68, 1'b0, FACE_BOTH));
        send_coin(mk_coin(112, 116, 1'b0, FACE_BOTH));
        send_coin(mk_coin(180, 136, 1'b0, FACE_BOTH));
        send_coin(mk_coin(190, 155, 1'b0, FACE_BOTH));
        // loonie and toonie windows overlap here; loonie has priority
        send_coin(mk_coin(180, 144, 1'b0, FACE_BOTH));
        // nickel window corners and one code below
        send_coin(mk_coin(92, 87, 1'b0, FACE_BOTH));
        send_coin(mk_coin(109, 100, 1'b0, FACE_BOTH));
        send_coin(mk_coin(91, 87, 1'b0, FACE_BOTH));
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_NICKEL_ROLL, 13'd1, 1'b1);
        write_reg(REG_DIME_ROLL, 13'h1FC0, 1'b1);   // low bits zero: every dime closes a roll
        write_reg(REG_QUARTER_ROLL, 13'd63, 1'b1);
        write_reg(REG_LOONIE_ROLL, 13'h1FFF, 1'b1);
        write_reg(REG_TOONIE_ROLL, 13'd2, 1'b1);
        write_reg(REG_BENT_LIMIT, 13'd0, 1'b1);
        write_reg(REG_OTHER_LIMIT, 13'h1FFF, 1'b1);
        write_reg(REG_UNUSED, 13'h1555, 1'b0);
        send_coin(mk_coin(0, 5, 1'b1, FACE_NONE));
        for (int i = 0; i < 40; i++)
            send_coin(random_coin());
        drain_results();
    endtask

    task automatic test_roll_shrink();
        write_reg(REG_NICKEL_ROLL, 13'd63, 1'b0);
        for (int i = 0; i < 8; i++)
            send_coin(mk_coin(100, 93, 1'b0, FACE_BOTH));
        drain_results();
        // size now below the count: next nickel closes the roll
        write_reg(REG_NICKEL_ROLL, 13'd3, 1'b0);
        send_coin(mk_coin(100, 93, 1'b0, FACE_BOTH));
        send_coin(mk_coin(104, 90, 1'b0, FACE_BOTH));
        drain_results();
    endtask

    task automatic test_random_mix(input int n, input int src, input int sink);
        for (int k = 0; k < NUM_KINDS; k++)
            write_reg(reg_index_t'(k), {7'($urandom), 6'($urandom_range(12))}, 1'b1);
        write_reg(REG_BENT_LIMIT, 13'($urandom_range(3000, 200)), 1'b1);
        write_reg(REG_OTHER_LIMIT, 13'($urandom_range(6000, 300)), 1'b0);
        src_idle_pct = src;
        sink_idle_pct = sink;
        for (int i = 0; i < n; i++)
        begin
            // hold off midway until every pending result has come back
            if (i == n / 2)
                drain_results();
            send_coin(random_coin());
        end
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_register_extremes();
        test_roll_shrink();
        test_random_mix(225, 6, 84);
        test_random_mix(225, 84, 6);
        test_random_mix(225, 0, 0);
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
